>>> rtl/lvpr_pkg.sv
package lvpr_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 11;

    localparam logic [CHAR_W-1:0] OPEN_BYTE = 8'h28;

endpackage

>>> rtl/lvpr_ram.sv
module lvpr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/longest_valid_paren_run_top.sv
// Latency: a string's result appears in the cycle after its last character is accepted.
// Throughput: one character per cycle; a last character stalls only while the prior
// result is still held by out_stall. The cached top pair plus a RAM read one entry below
// it lets a push or a pop with its length compare go every cycle.
// Reset (rst_n, async, active low) clears stack count, position, base, best length,
// overflow flag and output valid; each last character clears the string state again.
module longest_valid_paren_run_top
    import lvpr_pkg::*;
#(
    parameter int MAX_CHARS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] character,
    input  logic              last_char,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LEN_W-1:0]  longest_length,
    output logic              too_long
);

    localparam int PTR_W = $clog2(MAX_CHARS);
    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    // position + 1 of the last unmatched closer (0 means before string start)
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             ovf_reg, ovf_next;
    logic [PTR_W-1:0] top_reg, top_next;
    logic [PTR_W-1:0] under_reg, under_next;
    logic             out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             in_acc;
    logic             in_full;
    logic             is_open;
    logic             do_push;
    logic             do_pop;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] rd_idx;
    logic [PTR_W-1:0] raddr;
    logic [PTR_W-1:0] rdata;

    assign in_stall = out_valid_reg && out_stall && last_char;
    assign in_acc   = in_valid && !in_stall;
    assign in_full  = (pos_reg == CNT_W'(MAX_CHARS));
    assign is_open  = (character == OPEN_BYTE);
    assign do_push  = in_acc && !in_full && is_open;
    assign do_pop   = in_acc && !in_full && !is_open && (cnt_reg != '0);

    always_comb
    begin
        if (cnt_reg == CNT_W'(1))
        begin
            run = pos_reg + CNT_W'(1) - base_reg;
        end
        else
        begin
            run = pos_reg - CNT_W'(under_reg);
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        under_next     = under_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;

        if (in_acc)
        begin
            if (in_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + CNT_W'(1);
                if (is_open)
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    under_next = top_reg;
                    top_next   = pos_reg[PTR_W-1:0];
                end
                else if (cnt_reg == '0)
                begin
                    base_next = pos_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    top_next   = under_reg;
                    under_next = rdata;
                    if (run > best_reg)
                    begin
                        best_next = run;
                    end
                end
            end

            if (last_char)
            begin
                out_valid_next = 1'b1;
                out_len_next   = LEN_W'(best_next);
                out_ovf_next   = ovf_next;
                cnt_next       = '0;
                pos_next       = '0;
                base_next      = '0;
                best_next      = '0;
                ovf_next       = 1'b0;
            end
        end
    end

    // prefetch the entry just below the cached pair for the next cycle
    assign rd_idx = cnt_next - CNT_W'(3);
    assign raddr  = (cnt_next >= CNT_W'(3)) ? rd_idx[PTR_W-1:0] : '0;

    lvpr_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_CHARS)
    ) u_stack (
        .clk   (clk),
        .we    (do_push),
        .waddr (cnt_reg[PTR_W-1:0]),
        .wdata (pos_reg[PTR_W-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pos_reg       <= '0;
            base_reg      <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        under_reg   <= under_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign longest_length = out_len_reg;
    assign too_long       = out_ovf_reg;

    a_cnt_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pos_reg)
        else $error("stack count exceeds position");

    a_best_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= pos_reg)
        else $error("best length exceeds position");

    a_base_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= pos_reg)
        else $error("unmatched base beyond position");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_char |=> (pos_reg == '0) && (cnt_reg == '0) && out_valid_reg)
        else $error("state not cleared after last character");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> (cnt_reg != '0) && (pos_next == pos_reg + CNT_W'(1) || last_char))
        else $error("pop on empty stack");

endmodule
